@@ rtl/scp_pkg.sv @@
// Shared types, constants and CRC helpers for the serial command parser.
package scp_pkg;

  localparam int unsigned HIST_DEPTH  = 5;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned COUNT_LIMIT = 40;
  localparam int unsigned Q_DEPTH     = 4;
  localparam int unsigned Q_AW        = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW        = $clog2(Q_DEPTH + 1);
  localparam int unsigned IDX_W       = 3;

  localparam logic [7:0]  REQ_B0    = 8'h10;
  localparam logic [7:0]  REQ_B1    = 8'h18;
  localparam logic [7:0]  SPD_B0    = 8'h06;
  localparam logic [7:0]  SPD_B1    = 8'h10;
  localparam logic [7:0]  SPD_B2    = 8'h07;
  localparam logic [7:0]  HDR_ADDR  = 8'h0B;
  localparam logic [7:0]  HDR_FUNC  = 8'h03;
  localparam logic [7:0]  HDR_LEN   = 8'h02;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [IDX_W-1:0] IDX_POS_HI = 3'd3;
  localparam logic [IDX_W-1:0] IDX_POS_LO = 3'd4;
  localparam logic [IDX_W-1:0] IDX_CRC_LO = 3'd5;
  localparam logic [IDX_W-1:0] IDX_CRC_HI = 3'd6;

  typedef enum logic {
    KIND_REPLY = 1'b0,
    KIND_SPEED = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_REPLY
  } back_state_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } push_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [IDX_W-1:0] idx,
                                            input logic [15:0] pos,
                                            input logic [15:0] crc);
    logic [7:0] b;
    unique case (idx)
      3'd0:       b = HDR_ADDR;
      3'd1:       b = HDR_FUNC;
      3'd2:       b = HDR_LEN;
      IDX_POS_HI: b = pos[15:8];
      IDX_POS_LO: b = pos[7:0];
      IDX_CRC_LO: b = crc[7:0];
      IDX_CRC_HI: b = crc[15:8];
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/serial_command_parser_with_crc_reply.sv @@
// Top level: serial command parser with CRC-16 position reply.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o | rx_byte_i, position_value_i
//   out     | out_valid_o/out_ready_i | kind_o, tx_byte_o, speed_word_o, last_o
//
// One input beat per cycle while the four-entry command queue has room.
// A position reply leaves as seven output beats, one per cycle while
// out_ready_i is high, the first registered in the cycle that pops its
// command; the reply engine emits one byte per cycle. A speed update leaves
// as a single beat. Reset clears window, count, queue and output valid flag.
// Output stalls back up into the queue, then into in_ready_o.
module serial_command_parser_with_crc_reply (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] position_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic [15:0] speed_word_o,
  output logic        last_o
);

  scp_pkg::push_t push;
  scp_pkg::cmd_t  head;
  logic           full;
  logic           empty;
  logic           pop;

  scp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .position_value_i (position_value_i),
    .full_i           (full),
    .push_o           (push)
  );

  scp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  scp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .tx_byte_o    (tx_byte_o),
    .speed_word_o (speed_word_o),
    .last_o       (last_o)
  );

endmodule

@@ rtl/scp_front.sv @@
// Front end: byte window, frame count and command classification.
module scp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,
  input  logic [15:0]          position_value_i,
  input  logic                 full_i,
  output scp_pkg::push_t       push_o
);

  logic [7:0]                  hist_q [scp_pkg::HIST_DEPTH];
  logic [7:0]                  hist_d [scp_pkg::HIST_DEPTH];
  logic [scp_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic [scp_pkg::COUNT_W:0]   cnt_inc;
  logic                        accept;
  logic                        armed;
  logic                        hit_req;
  logic                        hit_spd;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cnt_inc    = {1'b0, cnt_q} + 1'b1;
  assign armed      = cnt_inc > (scp_pkg::COUNT_W+1)'(5);

  // window as it stands after this byte: oldest hist_q[1], newest rx_byte_i
  assign hit_req = armed && hist_q[4] == scp_pkg::REQ_B0 && rx_byte_i == scp_pkg::REQ_B1;
  assign hit_spd = armed && !hit_req && hist_q[1] == scp_pkg::SPD_B0
                   && hist_q[2] == scp_pkg::SPD_B1 && hist_q[3] == scp_pkg::SPD_B2;

  always_comb begin
    for (int i = 0; i < scp_pkg::HIST_DEPTH - 1; i++) begin
      hist_d[i] = hist_q[i+1];
    end
    hist_d[scp_pkg::HIST_DEPTH-1] = rx_byte_i;
  end

  always_comb begin
    if (hit_req || hit_spd) begin
      cnt_d = '0;
    end else if (cnt_inc > (scp_pkg::COUNT_W+1)'(scp_pkg::COUNT_LIMIT)) begin
      cnt_d = '0;
    end else begin
      cnt_d = cnt_inc[scp_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    push_o.valid = accept && (hit_req || hit_spd);
    if (hit_req) begin
      push_o.cmd.kind = scp_pkg::KIND_REPLY;
      push_o.cmd.data = position_value_i;
    end else begin
      push_o.cmd.kind = scp_pkg::KIND_SPEED;
      push_o.cmd.data = {hist_q[4], rx_byte_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < scp_pkg::HIST_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (accept) begin
      cnt_q  <= cnt_d;
      hist_q <= hist_d;
    end
  end

endmodule

@@ rtl/scp_fifo.sv @@
// Short command queue between the front end and the reply engine.
module scp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scp_pkg::push_t  push_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output scp_pkg::cmd_t   head_o
);

  scp_pkg::cmd_t            mem_q [scp_pkg::Q_DEPTH];
  logic [scp_pkg::Q_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [scp_pkg::Q_CW-1:0] cnt_q, cnt_d;
  logic                     do_push, do_pop;

  assign full_o  = cnt_q == scp_pkg::Q_CW'(scp_pkg::Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i.valid && full_o))
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("command popped from an empty queue");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != scp_pkg::Q_CW'(scp_pkg::Q_DEPTH)) |->
      (scp_pkg::Q_AW'(wr_ptr_q - rd_ptr_q) == cnt_q[scp_pkg::Q_AW-1:0]))
    else $error("queue pointers disagree with fill count");

endmodule

@@ rtl/scp_back.sv @@
// Back end: turns queued commands into reply bytes or speed updates.
module scp_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  scp_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          kind_o,
  output logic [7:0]    tx_byte_o,
  output logic [15:0]   speed_word_o,
  output logic          last_o
);

  scp_pkg::back_state_e      state_q, state_d;
  logic [scp_pkg::IDX_W-1:0] idx_q;
  logic [15:0]               pos_q;
  logic [15:0]               crc_q;
  logic                      load_en;
  logic                      produce;
  logic                      start_reply;
  logic                      kind_b;
  logic [7:0]                tx_b;
  logic [15:0]               spd_b;
  logic                      last_b;
  logic [15:0]               crc_base;
  logic                      out_valid_q;
  logic                      kind_q;
  logic [7:0]                tx_q;
  logic [15:0]               spd_q;
  logic                      last_q;

  assign load_en  = !out_valid_q || out_ready_i;
  assign crc_base = (state_q == scp_pkg::ST_IDLE) ? scp_pkg::CRC_INIT : crc_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scp_pkg::ST_IDLE: begin
        if (start_reply) begin
          state_d = scp_pkg::ST_REPLY;
        end
      end
      scp_pkg::ST_REPLY: begin
        if (produce && idx_q == scp_pkg::IDX_CRC_HI) begin
          state_d = scp_pkg::ST_IDLE;
        end
      end
      default: state_d = scp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = 1'b0;
    produce     = 1'b0;
    start_reply = 1'b0;
    kind_b      = scp_pkg::KIND_REPLY;
    tx_b        = '0;
    spd_b       = '0;
    last_b      = 1'b0;
    unique case (state_q)
      scp_pkg::ST_IDLE: begin
        if (!empty_i && load_en) begin
          pop_o   = 1'b1;
          produce = 1'b1;
          if (head_i.kind == scp_pkg::KIND_SPEED) begin
            kind_b = scp_pkg::KIND_SPEED;
            spd_b  = head_i.data;
            last_b = 1'b1;
          end else begin
            start_reply = 1'b1;
            tx_b        = scp_pkg::HDR_ADDR;
          end
        end
      end
      scp_pkg::ST_REPLY: begin
        if (load_en) begin
          produce = 1'b1;
          tx_b    = scp_pkg::reply_byte(idx_q, pos_q, crc_q);
          last_b  = idx_q == scp_pkg::IDX_CRC_HI;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scp_pkg::ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_reply) begin
        idx_q <= scp_pkg::IDX_W'(1);
      end else if (produce && state_q == scp_pkg::ST_REPLY) begin
        idx_q <= idx_q + 1'b1;
      end
      if (load_en) begin
        out_valid_q <= produce;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_reply) begin
      pos_q <= head_i.data;
    end
    if (start_reply || (produce && state_q == scp_pkg::ST_REPLY
                        && idx_q < scp_pkg::IDX_CRC_LO)) begin
      crc_q <= scp_pkg::crc_byte(crc_base, tx_b);
    end
    if (produce) begin
      kind_q <= kind_b;
      tx_q   <= tx_b;
      spd_q  <= spd_b;
      last_q <= last_b;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign tx_byte_o    = tx_q;
  assign speed_word_o = spd_q;
  assign last_o       = last_q;

  a_speed_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o) |-> last_o)
    else $error("speed update beat without last");

  a_reply_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scp_pkg::ST_REPLY) |-> (idx_q != '0 && idx_q <= scp_pkg::IDX_CRC_HI))
    else $error("reply byte index out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(kind_o) && $stable(tx_byte_o)
       && $stable(speed_word_o) && $stable(last_o)))
    else $error("output beat changed while stalled");

endmodule
